@@ src/cpt_pkg.sv @@
`default_nettype none

package cpt_pkg;

   localparam int SQRT_STEPS     = 32;
   localparam int SQRT_PER_STAGE = 2;
   localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;
   localparam int DIV_STEPS      = 32;
   localparam int DIV_PER_STAGE  = 2;
   localparam int DIV_STAGES     = DIV_STEPS / DIV_PER_STAGE;

   typedef struct packed {
      logic               ext;
      logic               cw;
      logic signed [31:0] c1x;
      logic signed [31:0] c1y;
      logic        [30:0] r1;
      logic signed [31:0] c2x;
      logic signed [31:0] c2y;
      logic        [30:0] r2;
   } base_type;

   typedef struct packed {
      base_type           base;
      logic               ok;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] rs;
      logic        [32:0] q;
   } side_type;

   typedef struct packed {
      base_type base;
      logic     ok;
      logic     sx;
      logic     sy;
      logic     qz;
   } div_side_type;

   typedef struct packed {
      logic               valid_res;
      logic signed [31:0] point1_x;
      logic signed [31:0] point1_y;
      logic signed [31:0] point2_x;
      logic signed [31:0] point2_y;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
   } res_type;

endpackage

`default_nettype wire

@@ src/cpt_front.sv @@
`default_nettype none

module cpt_front import cpt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     valid_in,
   input  base_type data_in,
   input  logic     stall_in,
   output logic     stall_out,
   output logic     valid_out,
   output side_type side_out,
   output logic [63:0] rad_out
);

   localparam int NS = 7;

   typedef struct packed {
      base_type           base;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] rr;
   } s1_type;

   typedef struct packed {
      base_type           base;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] rr;
      logic        [31:0] ux;
      logic        [31:0] uy;
      logic        [31:0] ur;
      logic               zero;
   } s2_type;

   typedef struct packed {
      base_type           base;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] rr;
      logic               zero;
      logic        [63:0] sqx;
      logic        [63:0] sqy;
      logic        [63:0] sqr;
      logic        [31:0] m;
   } s3_type;

   typedef struct packed {
      base_type           base;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] rr;
      logic               ok;
      logic        [5:0]  lz;
   } s4_type;

   typedef struct packed {
      base_type           base;
      logic               ok;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] rs;
   } s5_type;

   typedef struct packed {
      base_type           base;
      logic               ok;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] rs;
      logic        [63:0] sqa;
      logic        [63:0] sqb;
      logic        [63:0] sqrs;
   } s6_type;

   function automatic logic [31:0] abs_lo(input logic [33:0] v);
      logic [33:0] t;
      t = v[33] ? -v : v;
      return t[31:0];
   endfunction

   function automatic logic [5:0] lead_zeros(input logic [31:0] v);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            n = 6'(31 - i);
         end
      end
      return n;
   endfunction

   // halve toward zero, or normalize so the largest magnitude reaches bit 30
   function automatic logic [31:0] scale(input logic [33:0] v, input logic [5:0] lz);
      logic [33:0] t;
      if (lz == 6'd0) begin
         t = $signed(v + {33'd0, v[33]}) >>> 1;
      end else begin
         t = v << (lz - 6'd1);
      end
      return t[31:0];
   endfunction

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_src;
   logic [NS-1:0] hold;

   s1_type   s1_in, s1_ff;
   s2_type   s2_in, s2_ff;
   s3_type   s3_in, s3_ff;
   s4_type   s4_in, s4_ff;
   s5_type   s5_in, s5_ff;
   s6_type   s6_in, s6_ff;
   side_type side_in, side_ff;
   logic [63:0] rad_in, rad_ff;
   logic [63:0] d2;
   logic [65:0] diff;

   always_comb begin
      hold[NS-1] = v_ff[NS-1] & stall_in;
      for (int k = NS - 2; k >= 0; k--) begin
         hold[k] = v_ff[k] & hold[k+1];
      end
   end

   assign v_src     = {v_ff[NS-2:0], valid_in};
   assign stall_out = hold[0];
   assign valid_out = v_ff[NS-1];
   assign side_out  = side_ff;
   assign rad_out   = rad_ff;

   always_comb begin
      s1_in.base = data_in;
      s1_in.dx   = {{2{data_in.c2x[31]}}, data_in.c2x} - {{2{data_in.c1x[31]}}, data_in.c1x};
      s1_in.dy   = {{2{data_in.c2y[31]}}, data_in.c2y} - {{2{data_in.c1y[31]}}, data_in.c1y};
      s1_in.rr   = data_in.ext ? {3'd0, data_in.r1} - {3'd0, data_in.r2}
                               : {3'd0, data_in.r1} + {3'd0, data_in.r2};

      s2_in.base = s1_ff.base;
      s2_in.dx   = s1_ff.dx;
      s2_in.dy   = s1_ff.dy;
      s2_in.rr   = s1_ff.rr;
      s2_in.ux   = abs_lo(s1_ff.dx);
      s2_in.uy   = abs_lo(s1_ff.dy);
      s2_in.ur   = abs_lo(s1_ff.rr);
      s2_in.zero = (s1_ff.dx == 34'sd0) && (s1_ff.dy == 34'sd0);

      s3_in.base = s2_ff.base;
      s3_in.dx   = s2_ff.dx;
      s3_in.dy   = s2_ff.dy;
      s3_in.rr   = s2_ff.rr;
      s3_in.zero = s2_ff.zero;
      s3_in.sqx  = 64'(s2_ff.ux) * 64'(s2_ff.ux);
      s3_in.sqy  = 64'(s2_ff.uy) * 64'(s2_ff.uy);
      s3_in.sqr  = 64'(s2_ff.ur) * 64'(s2_ff.ur);
      s3_in.m    = (s2_ff.ux > s2_ff.uy) ? s2_ff.ux : s2_ff.uy;
      if (s2_ff.ur > s3_in.m) begin
         s3_in.m = s2_ff.ur;
      end

      s4_in.base = s3_ff.base;
      s4_in.dx   = s3_ff.dx;
      s4_in.dy   = s3_ff.dy;
      s4_in.rr   = s3_ff.rr;
      s4_in.ok   = !s3_ff.zero &&
                   ({1'b0, s3_ff.sqr} <= ({1'b0, s3_ff.sqx} + {1'b0, s3_ff.sqy}));
      s4_in.lz   = lead_zeros(s3_ff.m);

      s5_in.base = s4_ff.base;
      s5_in.ok   = s4_ff.ok;
      s5_in.a    = scale(s4_ff.dx, s4_ff.lz);
      s5_in.b    = scale(s4_ff.dy, s4_ff.lz);
      s5_in.rs   = scale(s4_ff.rr, s4_ff.lz);

      s6_in.base = s5_ff.base;
      s6_in.ok   = s5_ff.ok;
      s6_in.a    = s5_ff.a;
      s6_in.b    = s5_ff.b;
      s6_in.rs   = s5_ff.rs;
      s6_in.sqa  = s5_ff.a * s5_ff.a;
      s6_in.sqb  = s5_ff.b * s5_ff.b;
      s6_in.sqrs = s5_ff.rs * s5_ff.rs;

      d2           = s6_ff.sqa + s6_ff.sqb;
      diff         = {2'd0, s6_ff.sqa} + {2'd0, s6_ff.sqb} - {2'd0, s6_ff.sqrs};
      side_in.base = s6_ff.base;
      side_in.ok   = s6_ff.ok;
      side_in.a    = s6_ff.a;
      side_in.b    = s6_ff.b;
      side_in.rs   = s6_ff.rs;
      side_in.q    = d2[62:30];
      rad_in       = diff[65] ? 64'd0 : diff[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (!hold[k]) begin
               v_ff[k] <= v_src[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!hold[0]) begin
         s1_ff <= s1_in;
      end
      if (!hold[1]) begin
         s2_ff <= s2_in;
      end
      if (!hold[2]) begin
         s3_ff <= s3_in;
      end
      if (!hold[3]) begin
         s4_ff <= s4_in;
      end
      if (!hold[4]) begin
         s5_ff <= s5_in;
      end
      if (!hold[5]) begin
         s6_ff <= s6_in;
      end
      if (!hold[6]) begin
         side_ff <= side_in;
         rad_ff  <= rad_in;
      end
   end

endmodule

`default_nettype wire

@@ src/cpt_isqrt.sv @@
`default_nettype none

module cpt_isqrt import cpt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        valid_in,
   input  logic [63:0] rad_in,
   input  side_type    side_in,
   input  logic        stall_in,
   output logic        stall_out,
   output logic        valid_out,
   output logic [31:0] root_out,
   output side_type    side_out
);

   localparam int NS = SQRT_STAGES;

   typedef struct packed {
      logic [35:0] rem;
      logic [31:0] root;
      logic [63:0] x;
   } sq_type;

   // digit-by-digit floor square root, two result bits per stage
   function automatic sq_type sq_steps(input sq_type s);
      sq_type      r;
      logic [35:0] trial;
      r = s;
      for (int i = 0; i < SQRT_PER_STAGE; i++) begin
         r.rem = {r.rem[33:0], r.x[63:62]};
         r.x   = {r.x[61:0], 2'b00};
         trial = {2'b00, r.root, 2'b01};
         if (r.rem >= trial) begin
            r.rem  = r.rem - trial;
            r.root = {r.root[30:0], 1'b1};
         end else begin
            r.root = {r.root[30:0], 1'b0};
         end
      end
      return r;
   endfunction

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_src;
   logic [NS-1:0] hold;
   sq_type   st_src [NS];
   sq_type   st_in  [NS];
   sq_type   st_ff  [NS];
   side_type sd_src [NS];
   side_type sd_ff  [NS];

   always_comb begin
      hold[NS-1] = v_ff[NS-1] & stall_in;
      for (int k = NS - 2; k >= 0; k--) begin
         hold[k] = v_ff[k] & hold[k+1];
      end
   end

   always_comb begin
      st_src[0] = '{rem: 36'd0, root: 32'd0, x: rad_in};
      sd_src[0] = side_in;
      for (int k = 1; k < NS; k++) begin
         st_src[k] = st_ff[k-1];
         sd_src[k] = sd_ff[k-1];
      end
      for (int k = 0; k < NS; k++) begin
         st_in[k] = sq_steps(st_src[k]);
      end
   end

   assign v_src     = {v_ff[NS-2:0], valid_in};
   assign stall_out = hold[0];
   assign valid_out = v_ff[NS-1];
   assign root_out  = st_ff[NS-1].root;
   assign side_out  = sd_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (!hold[k]) begin
               v_ff[k] <= v_src[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (!hold[k]) begin
            st_ff[k] <= st_in[k];
            sd_ff[k] <= sd_src[k];
         end
      end
   end

endmodule

`default_nettype wire

@@ src/cpt_numer.sv @@
`default_nettype none

module cpt_numer import cpt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         valid_in,
   input  logic [31:0]  root_in,
   input  side_type     side_in,
   input  logic         stall_in,
   output logic         stall_out,
   output logic         valid_out,
   output logic [63:0]  nmx_out,
   output logic [63:0]  nmy_out,
   output logic [32:0]  dv_out,
   output div_side_type dside_out
);

   localparam int NS = 3;

   typedef struct packed {
      side_type           side;
      logic signed [63:0] rsa;
      logic signed [63:0] tb;
      logic signed [63:0] rsb;
      logic signed [63:0] ta;
   } n1_type;

   typedef struct packed {
      side_type           side;
      logic signed [63:0] nx;
      logic signed [63:0] ny;
   } n2_type;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_src;
   logic [NS-1:0] hold;
   n1_type n1_in, n1_ff;
   n2_type n2_in, n2_ff;
   logic signed [64:0] tb_w, ta_w;
   logic [63:0] nmx_in, nmx_ff, nmy_in, nmy_ff;
   logic [32:0] dv_in, dv_ff;
   div_side_type ds_in, ds_ff;

   always_comb begin
      hold[NS-1] = v_ff[NS-1] & stall_in;
      for (int k = NS - 2; k >= 0; k--) begin
         hold[k] = v_ff[k] & hold[k+1];
      end
   end

   always_comb begin
      tb_w      = $signed({1'b0, root_in}) * side_in.b;
      ta_w      = $signed({1'b0, root_in}) * side_in.a;
      n1_in.side = side_in;
      n1_in.rsa  = side_in.rs * side_in.a;
      n1_in.rsb  = side_in.rs * side_in.b;
      n1_in.tb   = tb_w[63:0];
      n1_in.ta   = ta_w[63:0];

      n2_in.side = n1_ff.side;
      if (n1_ff.side.base.cw) begin
         n2_in.nx = n1_ff.rsa - n1_ff.tb;
         n2_in.ny = n1_ff.rsb + n1_ff.ta;
      end else begin
         n2_in.nx = n1_ff.rsa + n1_ff.tb;
         n2_in.ny = n1_ff.rsb - n1_ff.ta;
      end

      nmx_in     = n2_ff.nx[63] ? -n2_ff.nx : n2_ff.nx;
      nmy_in     = n2_ff.ny[63] ? -n2_ff.ny : n2_ff.ny;
      dv_in      = n2_ff.side.q;
      ds_in.base = n2_ff.side.base;
      ds_in.ok   = n2_ff.side.ok;
      ds_in.sx   = n2_ff.nx[63];
      ds_in.sy   = n2_ff.ny[63];
      ds_in.qz   = (n2_ff.side.q == 33'd0);
   end

   assign v_src     = {v_ff[NS-2:0], valid_in};
   assign stall_out = hold[0];
   assign valid_out = v_ff[NS-1];
   assign nmx_out   = nmx_ff;
   assign nmy_out   = nmy_ff;
   assign dv_out    = dv_ff;
   assign dside_out = ds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (!hold[k]) begin
               v_ff[k] <= v_src[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!hold[0]) begin
         n1_ff <= n1_in;
      end
      if (!hold[1]) begin
         n2_ff <= n2_in;
      end
      if (!hold[2]) begin
         nmx_ff <= nmx_in;
         nmy_ff <= nmy_in;
         dv_ff  <= dv_in;
         ds_ff  <= ds_in;
      end
   end

endmodule

`default_nettype wire

@@ src/cpt_div.sv @@
`default_nettype none

module cpt_div import cpt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         valid_in,
   input  logic [63:0]  nmx_in,
   input  logic [63:0]  nmy_in,
   input  logic [32:0]  dv_in,
   input  div_side_type dside_in,
   input  logic         stall_in,
   output logic         stall_out,
   output logic         valid_out,
   output logic [31:0]  qx_out,
   output logic [31:0]  qy_out,
   output div_side_type dside_out
);

   localparam int NS = DIV_STAGES;

   typedef struct packed {
      logic [32:0] rx;
      logic [31:0] lx;
      logic [32:0] ry;
      logic [31:0] ly;
      logic [32:0] dv;
   } dv_type;

   // restoring division; quotient bits shift in where dividend bits leave
   function automatic dv_type dv_steps(input dv_type s);
      dv_type      r;
      logic [33:0] t;
      logic [33:0] d;
      r = s;
      for (int i = 0; i < DIV_PER_STAGE; i++) begin
         t = {r.rx, r.lx[31]};
         d = t - {1'b0, r.dv};
         if (t >= {1'b0, r.dv}) begin
            r.rx = d[32:0];
            r.lx = {r.lx[30:0], 1'b1};
         end else begin
            r.rx = t[32:0];
            r.lx = {r.lx[30:0], 1'b0};
         end
         t = {r.ry, r.ly[31]};
         d = t - {1'b0, r.dv};
         if (t >= {1'b0, r.dv}) begin
            r.ry = d[32:0];
            r.ly = {r.ly[30:0], 1'b1};
         end else begin
            r.ry = t[32:0];
            r.ly = {r.ly[30:0], 1'b0};
         end
      end
      return r;
   endfunction

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_src;
   logic [NS-1:0] hold;
   dv_type       st_src [NS];
   dv_type       st_in  [NS];
   dv_type       st_ff  [NS];
   div_side_type sd_src [NS];
   div_side_type sd_ff  [NS];

   always_comb begin
      hold[NS-1] = v_ff[NS-1] & stall_in;
      for (int k = NS - 2; k >= 0; k--) begin
         hold[k] = v_ff[k] & hold[k+1];
      end
   end

   always_comb begin
      st_src[0] = '{rx: {1'b0, nmx_in[63:32]}, lx: nmx_in[31:0],
                    ry: {1'b0, nmy_in[63:32]}, ly: nmy_in[31:0], dv: dv_in};
      sd_src[0] = dside_in;
      for (int k = 1; k < NS; k++) begin
         st_src[k] = st_ff[k-1];
         sd_src[k] = sd_ff[k-1];
      end
      for (int k = 0; k < NS; k++) begin
         st_in[k] = dv_steps(st_src[k]);
      end
   end

   assign v_src     = {v_ff[NS-2:0], valid_in};
   assign stall_out = hold[0];
   assign valid_out = v_ff[NS-1];
   assign qx_out    = st_ff[NS-1].lx;
   assign qy_out    = st_ff[NS-1].ly;
   assign dside_out = sd_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (!hold[k]) begin
               v_ff[k] <= v_src[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (!hold[k]) begin
            st_ff[k] <= st_in[k];
            sd_ff[k] <= sd_src[k];
         end
      end
   end

endmodule

`default_nettype wire

@@ src/cpt_back.sv @@
`default_nettype none

module cpt_back import cpt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         valid_in,
   input  logic [31:0]  qx_in,
   input  logic [31:0]  qy_in,
   input  div_side_type dside_in,
   input  logic         stall_in,
   output logic         stall_out,
   output logic         valid_out,
   output res_type      res_out
);

   localparam int NS = 3;

   typedef struct packed {
      div_side_type ds;
      logic [62:0]  p1x;
      logic [62:0]  p1y;
      logic [62:0]  p2x;
      logic [62:0]  p2y;
      logic [16:0]  nmx;
      logic [16:0]  nmy;
   } b1_type;

   typedef struct packed {
      base_type           base;
      logic               ok;
      logic signed [34:0] o1x;
      logic signed [34:0] o1y;
      logic signed [34:0] o2x;
      logic signed [34:0] o2y;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
   } b2_type;

   function automatic logic [16:0] rnd16(input logic [31:0] e);
      logic [32:0] s;
      s = {1'b0, e} + 33'h0_0000_8000;
      return s[32:16];
   endfunction

   function automatic logic [34:0] offset(input logic [62:0] p, input logic neg);
      logic [63:0] s;
      logic [34:0] m;
      s = {1'b0, p} + 64'h0000_0000_2000_0000;
      m = {1'b0, s[63:30]};
      return neg ? -m : m;
   endfunction

   function automatic logic [15:0] norm(input logic [16:0] m, input logic neg);
      logic [16:0] t;
      t = -m;
      if (neg) begin
         return t[15:0];
      end
      return m[16] ? 16'h7fff : m[15:0];
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] c, input logic [34:0] o);
      logic [35:0] s;
      s = {{4{c[31]}}, c} + {o[34], o};
      if (s[35:31] == 5'b00000 || s[35:31] == 5'b11111) begin
         return s[31:0];
      end
      return s[35] ? 32'h8000_0000 : 32'h7fff_ffff;
   endfunction

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_src;
   logic [NS-1:0] hold;
   b1_type  b1_in, b1_ff;
   b2_type  b2_in, b2_ff;
   res_type res_in, res_ff;
   logic [31:0] ex, ey;

   always_comb begin
      hold[NS-1] = v_ff[NS-1] & stall_in;
      for (int k = NS - 2; k >= 0; k--) begin
         hold[k] = v_ff[k] & hold[k+1];
      end
   end

   always_comb begin
      ex        = dside_in.qz ? 32'd0 : qx_in;
      ey        = dside_in.qz ? 32'd0 : qy_in;
      b1_in.ds  = dside_in;
      b1_in.p1x = 63'(dside_in.base.r1) * 63'(ex);
      b1_in.p1y = 63'(dside_in.base.r1) * 63'(ey);
      b1_in.p2x = 63'(dside_in.base.r2) * 63'(ex);
      b1_in.p2y = 63'(dside_in.base.r2) * 63'(ey);
      b1_in.nmx = rnd16(ex);
      b1_in.nmy = rnd16(ey);

      b2_in.base = b1_ff.ds.base;
      b2_in.ok   = b1_ff.ds.ok;
      b2_in.o1x  = offset(b1_ff.p1x, b1_ff.ds.sx);
      b2_in.o1y  = offset(b1_ff.p1y, b1_ff.ds.sy);
      // internal tangent: second point lies opposite the radial vector
      b2_in.o2x  = offset(b1_ff.p2x, b1_ff.ds.sx ^ !b1_ff.ds.base.ext);
      b2_in.o2y  = offset(b1_ff.p2y, b1_ff.ds.sy ^ !b1_ff.ds.base.ext);
      b2_in.nx   = norm(b1_ff.nmy, !b1_ff.ds.sy ^ b1_ff.ds.base.cw);
      b2_in.ny   = norm(b1_ff.nmx, b1_ff.ds.sx ^ b1_ff.ds.base.cw);

      res_in = '0;
      if (b2_ff.ok) begin
         res_in.valid_res = 1'b1;
         res_in.point1_x  = sat_add(b2_ff.base.c1x, b2_ff.o1x);
         res_in.point1_y  = sat_add(b2_ff.base.c1y, b2_ff.o1y);
         res_in.point2_x  = sat_add(b2_ff.base.c2x, b2_ff.o2x);
         res_in.point2_y  = sat_add(b2_ff.base.c2y, b2_ff.o2y);
         res_in.normal_x  = b2_ff.nx;
         res_in.normal_y  = b2_ff.ny;
      end
   end

   assign v_src     = {v_ff[NS-2:0], valid_in};
   assign stall_out = hold[0];
   assign valid_out = v_ff[NS-1];
   assign res_out   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (!hold[k]) begin
               v_ff[k] <= v_src[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!hold[0]) begin
         b1_ff <= b1_in;
      end
      if (!hold[1]) begin
         b2_ff <= b2_in;
      end
      if (!hold[2]) begin
         res_ff <= res_in;
      end
   end

endmodule

`default_nettype wire

@@ src/circle_pair_tangent_points.sv @@
// Pipeline stages per unit, from request accept to response valid:
// front 7, square root 16, numerator 3, divider 16, output 3.
// Throughput: one request per cycle while req_stall is low; a stage register moves unless it is
// full and the stage after it is held, so bubbles are squeezed out under stall.
// Reset clears the stage valid bits only; data registers are not reset.
`default_nettype none

module circle_pair_tangent_points import cpt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic               req_direction,
   input  logic signed [31:0] req_center1_x,
   input  logic signed [31:0] req_center1_y,
   input  logic        [30:0] req_radius1,
   input  logic signed [31:0] req_center2_x,
   input  logic signed [31:0] req_center2_y,
   input  logic        [30:0] req_radius2,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_valid_res,
   output logic signed [31:0] rsp_point1_x,
   output logic signed [31:0] rsp_point1_y,
   output logic signed [31:0] rsp_point2_x,
   output logic signed [31:0] rsp_point2_y,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y
);

   base_type     req_data;
   logic         fr_valid, fr_stall;
   side_type     fr_side;
   logic [63:0]  fr_rad;
   logic         sq_valid, sq_stall;
   logic [31:0]  sq_root;
   side_type     sq_side;
   logic         nu_valid, nu_stall;
   logic [63:0]  nu_nmx, nu_nmy;
   logic [32:0]  nu_dv;
   div_side_type nu_side;
   logic         dv_valid, dv_stall;
   logic [31:0]  dv_qx, dv_qy;
   div_side_type dv_side;
   res_type      res;

   assign req_data = '{ext: req_operation, cw: req_direction,
                       c1x: req_center1_x, c1y: req_center1_y, r1: req_radius1,
                       c2x: req_center2_x, c2y: req_center2_y, r2: req_radius2};

   cpt_front u_front (
      .clock(clock), .reset(reset),
      .valid_in(req_valid), .data_in(req_data),
      .stall_in(fr_stall), .stall_out(req_stall),
      .valid_out(fr_valid), .side_out(fr_side), .rad_out(fr_rad)
   );

   cpt_isqrt u_isqrt (
      .clock(clock), .reset(reset),
      .valid_in(fr_valid), .rad_in(fr_rad), .side_in(fr_side),
      .stall_in(sq_stall), .stall_out(fr_stall),
      .valid_out(sq_valid), .root_out(sq_root), .side_out(sq_side)
   );

   cpt_numer u_numer (
      .clock(clock), .reset(reset),
      .valid_in(sq_valid), .root_in(sq_root), .side_in(sq_side),
      .stall_in(nu_stall), .stall_out(sq_stall),
      .valid_out(nu_valid), .nmx_out(nu_nmx), .nmy_out(nu_nmy),
      .dv_out(nu_dv), .dside_out(nu_side)
   );

   cpt_div u_div (
      .clock(clock), .reset(reset),
      .valid_in(nu_valid), .nmx_in(nu_nmx), .nmy_in(nu_nmy),
      .dv_in(nu_dv), .dside_in(nu_side),
      .stall_in(dv_stall), .stall_out(nu_stall),
      .valid_out(dv_valid), .qx_out(dv_qx), .qy_out(dv_qy), .dside_out(dv_side)
   );

   cpt_back u_back (
      .clock(clock), .reset(reset),
      .valid_in(dv_valid), .qx_in(dv_qx), .qy_in(dv_qy), .dside_in(dv_side),
      .stall_in(rsp_stall), .stall_out(dv_stall),
      .valid_out(rsp_valid), .res_out(res)
   );

   assign rsp_valid_res = res.valid_res;
   assign rsp_point1_x  = res.point1_x;
   assign rsp_point1_y  = res.point1_y;
   assign rsp_point2_x  = res.point2_x;
   assign rsp_point2_y  = res.point2_y;
   assign rsp_normal_x  = res.normal_x;
   assign rsp_normal_y  = res.normal_y;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while output not held");

   a_no_tangent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |->
         (rsp_point1_x == 32'sd0 && rsp_point1_y == 32'sd0 &&
          rsp_point2_x == 32'sd0 && rsp_point2_y == 32'sd0 &&
          rsp_normal_x == 16'sd0 && rsp_normal_y == 16'sd0))
      else $error("no-tangent response carries nonzero fields");

   a_normal_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_valid_res) |-> (rsp_normal_x != 16'sd0 || rsp_normal_y != 16'sd0))
      else $error("valid tangent with zero normal");

endmodule

`default_nettype wire
